[sv/dpv_pkg.sv]
// Shared constants and types for the DPV waveform DAC sequencer.
// Holds register indexes, fixed-point widths and limits.
// No dependencies.
`default_nettype none

package dpv_pkg;

    // fixed-point format of the ramp and pulse codes
    localparam int C_FRAC_BITS = 8;
    localparam int C_MAX_STEPS = 1020;

    localparam int C_VZERO_W = 6;
    localparam int C_START_W = 21;
    localparam int C_STEP_W  = 17;
    localparam int C_PULSE_W = 17;
    localparam int C_TOTAL_W = 10;
    localparam int C_ACC_W   = 28;
    localparam int C_STEPS_W = 11;
    localparam int C_SUM_W   = 30;
    localparam int C_BIAS_W  = 12;
    localparam int C_VZ_SHIFT = 6;   // vzero * 64
    localparam int C_BIAS_MAX = 4095;

    localparam int C_DAC_W    = C_VZERO_W + C_BIAS_W;
    localparam int C_IDX_W    = 10;
    localparam int C_TDATA_W  = 32;
    localparam int C_TUSER_W  = 2;
    localparam int C_SDATA_W  = 8;
    localparam int C_ADDR_W   = 5;
    localparam int C_PDATA_W  = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_VZERO = 3'd0;
    localparam logic [2:0] REG_START = 3'd1;
    localparam logic [2:0] REG_STEP  = 3'd2;
    localparam logic [2:0] REG_PULSE = 3'd3;
    localparam logic [2:0] REG_TOTAL = 3'd4;

    // reset values of the registers
    localparam logic [C_VZERO_W-1:0] RST_VZERO = 6'd58;
    localparam logic signed [C_START_W-1:0] RST_START = -21'sd95301;
    localparam logic signed [C_STEP_W-1:0]  RST_STEP  = 17'sd2382;
    localparam logic signed [C_PULSE_W-1:0] RST_PULSE = 17'sd23825;
    localparam logic [C_TOTAL_W-1:0] RST_TOTAL = 10'd160;

    typedef logic [C_SDATA_W-1:0] t_sdata;
    typedef logic [C_TDATA_W-1:0] t_mdata;
    typedef logic [C_TUSER_W-1:0] t_muser;
    typedef logic [C_ADDR_W-1:0]  t_paddr;
    typedef logic [C_PDATA_W-1:0] t_pdata;

endpackage

`default_nettype wire

[sv/dpv_waveform_dac_sequencer.sv]
// DPV waveform DAC sequencer: staircase with a pulse on every step.
// Uses dpv_pkg for widths, limits and register indexes.
//
// Usage:
//   Slave stream (s_axis_*): each accepted word is one tick; tdata bit 0 is
//   restart, which returns the sequence to its start before the tick.
//   Master stream (m_axis_*): one DAC word per tick, in tick order.
//   APB port: five registers at byte addresses 0,4,8,12,16 (vzero, ramp
//   start, ramp step, pulse, step total); write only while the streams are
//   idle. pready is always high, reads return the stored value.
// Output: a result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while the output is taken; the sequencer state update, the bias add
//   and the clamp all sit between the accepted tick and the output register.
// Stall: while m_axis_tready is low the result holds and s_axis_tready drops
//   once the output register is full; a tick is accepted in the same cycle
//   that the held result is taken.
// Reset: registers return to their defaults, the sequence to its start and
//   the output register empties.
`default_nettype none

module dpv_waveform_dac_sequencer (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  dpv_pkg::t_sdata   s_axis_tdata,   // [0] restart, [7:1] zero
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output dpv_pkg::t_mdata         m_axis_tdata,   // [17:0] dac_word, [27:18] step_index
    output dpv_pkg::t_muser         m_axis_tuser,   // [0] pulse_on, [1] finished
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  dpv_pkg::t_paddr   paddr,
    input  wire  dpv_pkg::t_pdata   pwdata,
    output dpv_pkg::t_pdata         prdata,
    output logic                    pready
);
    import dpv_pkg::*;

    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_BASE  = 2'd1;
    localparam logic [1:0] PH_PULSE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // configuration
    logic [C_VZERO_W-1:0]        r_vzero;
    logic signed [C_START_W-1:0] r_start;
    logic signed [C_STEP_W-1:0]  r_step;
    logic signed [C_PULSE_W-1:0] r_pulse;
    logic [C_TOTAL_W-1:0]        r_total;

    // sequencer state
    logic [1:0]                  r_phase, n_phase;
    logic signed [C_ACC_W-1:0]   r_acc, n_acc;
    logic [C_STEPS_W-1:0]        r_steps, n_steps;
    logic                        r_flag, n_flag;

    // output register
    logic                        r_out_valid;
    logic [C_DAC_W-1:0]          r_out_dac;
    logic [C_IDX_W-1:0]          r_out_idx;
    logic                        r_out_pulse;
    logic                        r_out_fin;

    logic                        s_fire;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic                        restart;
    logic [1:0]                  cur_phase;
    logic signed [C_ACC_W-1:0]   cur_acc;
    logic [C_STEPS_W-1:0]        cur_steps;
    logic                        cur_flag;
    logic [C_STEPS_W-1:0]        total;
    logic [C_SUM_W-1:0]          w_base;
    logic signed [C_SUM_W-1:0]   w_sum;
    logic signed [C_SUM_W-1:0]   w_shift;
    logic [C_BIAS_W-1:0]         w_bias;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vzero <= RST_VZERO;
            r_start <= RST_START;
            r_step  <= RST_STEP;
            r_pulse <= RST_PULSE;
            r_total <= RST_TOTAL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VZERO: r_vzero <= pwdata[C_VZERO_W-1:0];
                REG_START: r_start <= pwdata[C_START_W-1:0];
                REG_STEP:  r_step  <= pwdata[C_STEP_W-1:0];
                REG_PULSE: r_pulse <= pwdata[C_PULSE_W-1:0];
                REG_TOTAL: r_total <= pwdata[C_TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_VZERO: prdata = C_PDATA_W'(r_vzero);
            REG_START: prdata = C_PDATA_W'(unsigned'(r_start));
            REG_STEP:  prdata = C_PDATA_W'(unsigned'(r_step));
            REG_PULSE: prdata = C_PDATA_W'(unsigned'(r_pulse));
            REG_TOTAL: prdata = C_PDATA_W'(r_total);
            default:   prdata = '0;
        endcase
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    always_comb begin
        cur_phase = restart ? PH_INIT : r_phase;
        cur_acc   = restart ? '0 : r_acc;
        cur_steps = restart ? '0 : r_steps;
        cur_flag  = restart ? 1'b0 : r_flag;
        total     = (r_total > C_TOTAL_W'(C_MAX_STEPS)) ? C_STEPS_W'(C_MAX_STEPS)
                                                        : C_STEPS_W'(r_total);
        n_phase = cur_phase;
        n_acc   = cur_acc;
        n_steps = cur_steps;
        n_flag  = cur_flag;
        case (cur_phase)
            PH_INIT: begin
                n_acc   = C_ACC_W'(r_start);
                n_flag  = 1'b0;
                n_steps = '0;
                n_phase = PH_BASE;
            end
            PH_BASE: begin
                if (!cur_flag) begin
                    n_phase = PH_PULSE;
                    n_flag  = 1'b1;
                end
            end
            PH_PULSE: begin
                if (cur_flag) begin
                    n_flag  = 1'b0;
                    n_steps = cur_steps + C_STEPS_W'(1);
                    n_acc   = cur_acc + C_ACC_W'(r_step);
                    n_phase = (n_steps >= total) ? PH_STOP : PH_BASE;
                end
            end
            default: ;
        endcase
    end

    // bias = vzero*64 + ramp (+ pulse), truncated and clamped to 0..4095
    always_comb begin
        w_base  = C_SUM_W'({r_vzero, {C_VZ_SHIFT{1'b0}}}) << C_FRAC_BITS;
        w_sum   = $signed(w_base) + C_SUM_W'(n_acc)
                  + (n_flag ? C_SUM_W'(r_pulse) : '0);
        w_shift = w_sum >>> C_FRAC_BITS;
        if (w_sum <= 0) begin
            w_bias = '0;
        end else if (w_shift > C_SUM_W'(C_BIAS_MAX)) begin
            w_bias = C_BIAS_W'(C_BIAS_MAX);
        end else begin
            w_bias = w_shift[C_BIAS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_acc       <= '0;
            r_steps     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_steps     <= n_steps;
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_dac   <= {r_vzero, w_bias};
            r_out_idx   <= n_steps[C_IDX_W-1:0];
            r_out_pulse <= n_flag;
            r_out_fin   <= (n_phase == PH_STOP);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = C_TDATA_W'({r_out_idx, r_out_dac});
    assign m_axis_tuser  = {r_out_fin, r_out_pulse};

endmodule

`default_nettype wire

[tb/dpv_waveform_dac_sequencer_test.sv]
// Self-checking testbench for dpv_waveform_dac_sequencer: ticks on the slave stream,
// DAC words on the master stream, checked against a cycle-free staircase predictor.
// Depends on dpv_pkg and the sequencer RTL only.

module dpv_waveform_dac_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpv_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_RUN     = 300;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_TICKS   = 80;

    typedef enum logic [1:0] {SEQ_INIT, SEQ_BASE, SEQ_PULSE, SEQ_HOLD} t_seq_phase;

    typedef struct {
        logic [C_DAC_W-1:0] dac_word;
        logic               pulse_on;
        logic [C_IDX_W-1:0] step_index;
        logic               finished;
    } t_dac_sample;

    class t_dac_scoreboard;
        logic [C_VZERO_W-1:0]        vzero;
        logic signed [C_START_W-1:0] ramp_start;
        logic signed [C_STEP_W-1:0]  ramp_inc;
        logic signed [C_PULSE_W-1:0] pulse_amp;
        logic [C_TOTAL_W-1:0]        step_total;

        t_seq_phase                  phase;
        logic signed [C_ACC_W-1:0]   ramp;
        logic [C_STEPS_W-1:0]        steps;
        bit                          pulse;

        t_dac_sample                 dac_q[$];
        int                          errors;

        function new();
            vzero      = RST_VZERO;
            ramp_start = RST_START;
            ramp_inc   = RST_STEP;
            pulse_amp  = RST_PULSE;
            step_total = RST_TOTAL;
            errors     = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            phase = SEQ_INIT;
            ramp  = '0;
            steps = '0;
            pulse = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_VZERO: vzero      = value[C_VZERO_W-1:0];
                REG_START: ramp_start = value[C_START_W-1:0];
                REG_STEP:  ramp_inc   = value[C_STEP_W-1:0];
                REG_PULSE: pulse_amp  = value[C_PULSE_W-1:0];
                REG_TOTAL: step_total = value[C_TOTAL_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return dac_q.size();
        endfunction

        // advance the staircase by one tick and queue the word it must produce
        function void note_tick(bit restart);
            int          lim;
            longint      sum;
            longint      bias;
            t_dac_sample s;
            lim = (step_total > C_MAX_STEPS) ? C_MAX_STEPS : int'(step_total);
            if (restart)
                clear_seq();
            case (phase)
                SEQ_INIT: begin
                    ramp  = ramp_start;
                    pulse = 1'b0;
                    steps = '0;
                    phase = SEQ_BASE;
                end
                SEQ_BASE: begin
                    if (!pulse) begin
                        phase = SEQ_PULSE;
                        pulse = 1'b1;
                    end
                end
                SEQ_PULSE: begin
                    if (pulse) begin
                        pulse = 1'b0;
                        steps = steps + 1'b1;
                        ramp  = ramp + ramp_inc;
                        phase = (steps >= lim) ? SEQ_HOLD : SEQ_BASE;
                    end
                end
                default: ;
            endcase
            sum = longint'(vzero) * 64 * (longint'(1) << C_FRAC_BITS) + longint'(ramp);
            if (pulse)
                sum += longint'(pulse_amp);
            if (sum <= 0) begin
                bias = 0;
            end else begin
                bias = sum >>> C_FRAC_BITS;
                if (bias > C_BIAS_MAX)
                    bias = C_BIAS_MAX;
            end
            s.dac_word   = {vzero, bias[C_BIAS_W-1:0]};
            s.pulse_on   = pulse;
            s.step_index = steps[C_IDX_W-1:0];
            s.finished   = (phase == SEQ_HOLD);
            dac_q.push_back(s);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_mdata tdata, t_muser tuser);
            t_dac_sample want;
            if (dac_q.size() == 0) begin
                $error("unexpected word: tdata=%h tuser=%b", tdata, tuser);
                errors++;
                return;
            end
            want = dac_q.pop_front();
            compare("dac_word", want.dac_word, tdata[C_DAC_W-1:0]);
            compare("step_index", want.step_index, tdata[C_DAC_W +: C_IDX_W]);
            compare("pulse_on", want.pulse_on, tuser[0]);
            compare("finished", want.finished, tuser[1]);
        endfunction
    endclass

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   s_axis_tvalid = 1'b0;
    logic   s_axis_tready;
    t_sdata s_axis_tdata  = '0;      // [0] restart, [7:1] zero
    logic   m_axis_tvalid;
    logic   m_axis_tready = 1'b0;
    t_mdata m_axis_tdata;            // [17:0] dac_word, [27:18] step_index
    t_muser m_axis_tuser;            // [0] pulse_on, [1] finished
    logic   psel          = 1'b0;
    logic   penable       = 1'b0;
    logic   pwrite        = 1'b0;
    t_paddr paddr         = '0;
    t_pdata pwdata        = '0;
    t_pdata prdata;
    logic   pready;

    t_dac_scoreboard sb;
    int max_gap   = 4;
    int stall_req = 0;
    int cycles    = 0;

    dpv_waveform_dac_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // psel stays high across back-to-back writes; configure() closes the burst
    task automatic write_reg(logic [2:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(int vz, int start, int inc, int amp, int total);
        write_reg(REG_VZERO, vz);
        write_reg(REG_START, start);
        write_reg(REG_STEP, inc);
        write_reg(REG_PULSE, amp);
        write_reg(REG_TOTAL, total);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_setup();
        int vz;
        int start;
        int inc;
        int amp;
        int total;
        int pick;
        vz = $urandom_range(0, 63);
        if ($urandom_range(0, 1))
            start = int'($urandom_range(0, 1048320)) - vz * 16384;
        else
            start = int'($urandom_range(0, 2097151)) - 1048576;
        if ($urandom_range(0, 1))
            inc = int'($urandom_range(0, 4000)) - 2000;
        else
            inc = int'($urandom_range(0, 131071)) - 65536;
        amp = int'($urandom_range(0, 131071)) - 65536;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            total = $urandom_range(1, 40);
        else if (pick == 7)
            total = 0;
        else
            total = $urandom_range(0, 1023);
        configure(vz, start, inc, amp, total);
    endtask

    task automatic send_tick(bit restart);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t_sdata'(restart);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(restart);
    endtask

    // restart flags, first tick in bit 0
    task automatic send_bits(int n, logic [31:0] restarts);
        for (int i = 0; i < n; i++)
            send_tick(restarts[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver: random gaps, plus long hold-offs on request
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_req > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_req) @(posedge i_clk);
                stall_req = 0;
            end
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        bit restart;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: restart from the base and from the pulse phase
        send_bits(10, 32'b0010100000);
        drain();
        // floor: negative bias clamps to zero, step total zero stops at once
        configure(0, -1048576, -65536, -65536, 0);
        send_bits(6, 32'b100001);
        drain();
        // ceiling: bias clamps to 4095, single step
        configure(63, 1048575, 65535, 65535, 1);
        send_bits(6, 32'b000001);
        drain();

        // step total above the limit, long back-to-back run with a receiver hold-off
        configure($urandom_range(0, 63), int'($urandom_range(0, 200000)) - 100000,
                  int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 131071)) - 65536,
                  1023);
        max_gap = 0;
        send_tick(1'b1);
        for (int i = 0; i < LONG_RUN; i++) begin
            if (i == 200)
                stall_req = 40;
            if (i == 150)
                max_gap = 4;
            send_tick(1'b0);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            random_setup();
            max_gap = (p % 3 == 0) ? 0 : 4;
            for (int i = 0; i < RAND_TICKS; i++) begin
                if (i == 0)
                    restart = ($urandom_range(0, 9) != 0);
                else if (p == 5)
                    restart = $urandom_range(0, 1);
                else
                    restart = ($urandom_range(0, 39) == 0);
                if (p == 3 && i == 60)
                    drain();
                if (p == 4 && i == 30)
                    stall_req = 60;
                send_tick(restart);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
